/* rtl/qpv_pkg.sv */
// shared types, constants and helpers for the quadrature position/velocity block
// no dependencies; imported by qpv_decode and quadrature_position_velocity
package qpv_pkg;

  // configuration register widths and reset values
  localparam int unsigned CprWidth       = 13;
  localparam int unsigned ScaleWidth     = 8;
  localparam int unsigned CfgDataWidth   = 13;
  localparam int unsigned CfgIndexWidth  = 1;
  localparam logic [CprWidth-1:0]   CPR_RESET   = 13'd4000;
  localparam logic [ScaleWidth-1:0] SCALE_RESET = 8'd3;

  // register indexes on the configuration port
  localparam logic [CfgIndexWidth-1:0] REG_COUNTS_PER_REV = 1'd0;
  localparam logic [CfgIndexWidth-1:0] REG_RPM_SCALE      = 1'd1;

  // default width of the saturating edge counter
  localparam int unsigned EDGE_COUNT_WIDTH_DEF = 16;

  // latched edge count saturates here
  localparam logic [15:0] LATCH_MAX = 16'hFFFF;

  // position and velocity state carried from one transaction to the next
  typedef struct packed {
    logic [1:0]         last_pins;
    logic signed [13:0] count;
    logic [31:0]        revs;
    logic [15:0]        latched_edges;
    logic [23:0]        latched_rpm;
  } qpv_state_t;

  // one result transaction
  typedef struct packed {
    logic signed [13:0] count_in_rev;
    logic [31:0]        revolutions;
    logic [15:0]        edges_in_window;
    logic [23:0]        speed_rpm;
    logic               window_done;
  } qpv_result_t;

  // pin state that precedes cur in the forward direction
  function automatic logic [1:0] forward_prev(input logic [1:0] cur);
    logic [1:0] prev;
    case (cur)
      2'b00:   prev = 2'b01;
      2'b01:   prev = 2'b11;
      2'b10:   prev = 2'b00;
      2'b11:   prev = 2'b10;
      default: prev = 2'b00;
    endcase
    return prev;
  endfunction

endpackage

/* rtl/qpv_decode.sv */
// x4 quadrature decode, position wrap and window latch for one sample
// depends on qpv_pkg; purely combinational, registered by the top level
module qpv_decode #(
  parameter int unsigned EW = qpv_pkg::EDGE_COUNT_WIDTH_DEF
) (
  input  logic                             pin_a_i,
  input  logic                             pin_b_i,
  input  logic                             window_tick_i,
  input  logic [qpv_pkg::CprWidth-1:0]     counts_per_rev_i,
  input  logic [qpv_pkg::ScaleWidth-1:0]   rpm_scale_i,
  input  qpv_pkg::qpv_state_t              state_i,
  input  logic [EW-1:0]                    edge_cnt_i,
  output qpv_pkg::qpv_state_t              state_o,
  output logic [EW-1:0]                    edge_cnt_o,
  output qpv_pkg::qpv_result_t             result_o
);
  import qpv_pkg::*;

  logic [1:0]         cur;
  logic               changed;
  logic               fwd;
  logic signed [14:0] cnt_step;
  logic signed [14:0] limit;
  logic               wrap_up;
  logic               wrap_dn;
  logic [EW-1:0]      edge_inc;
  logic [31:0]        edge_wide;
  logic [15:0]        edge_sat;
  logic [23:0]        rpm;

  // direction of the step against the previous pin state
  assign cur      = {pin_a_i, pin_b_i};
  assign changed  = (cur != state_i.last_pins);
  assign fwd      = (forward_prev(cur) == state_i.last_pins);
  assign cnt_step = {state_i.count[13], state_i.count} + (fwd ? 15'sd1 : -15'sd1);
  assign limit    = signed'({2'b00, counts_per_rev_i});
  assign wrap_up  = (cnt_step >= limit);
  assign wrap_dn  = (cnt_step <= -limit);

  // saturating edge count including this sample
  assign edge_inc  = (changed && (edge_cnt_i != '1)) ? edge_cnt_i + EW'(1) : edge_cnt_i;
  assign edge_wide = 32'(edge_inc);
  assign edge_sat  = (edge_wide > 32'(LATCH_MAX)) ? LATCH_MAX : edge_wide[15:0];
  assign rpm       = 24'(edge_sat * rpm_scale_i);

  // next state
  always_comb begin
    state_o = state_i;
    if (changed) begin
      state_o.last_pins = cur;
      if (wrap_up) begin
        state_o.count = '0;
        state_o.revs  = state_i.revs + 32'd1;
      end else if (wrap_dn) begin
        state_o.count = '0;
        state_o.revs  = state_i.revs - 32'd1;
      end else begin
        state_o.count = cnt_step[13:0];
      end
    end
    edge_cnt_o = edge_inc;
    if (window_tick_i) begin
      state_o.latched_edges = edge_sat;
      state_o.latched_rpm   = rpm;
      edge_cnt_o            = '0;
    end
  end

  // result fields follow the updated state
  always_comb begin
    result_o.count_in_rev    = state_o.count;
    result_o.revolutions     = state_o.revs;
    result_o.edges_in_window = state_o.latched_edges;
    result_o.speed_rpm       = state_o.latched_rpm;
    result_o.window_done     = window_tick_i;
  end

endmodule

/* rtl/quadrature_position_velocity.sv */
// top level of the quadrature position/velocity block: handshakes, config, state
// depends on qpv_pkg and qpv_decode
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries one sample of pin_a, pin_b and
//   window_tick per transaction; output channel (out_valid_o/out_ready_i) returns
//   exactly one result per input transaction, in order.
//   config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 counts_per_rev, 1 rpm_scale) at the clock edge; write only while idle.
// pipeline:
//   a sample is taken into the input register, then decoded and written into the
//   result register once that register is free; out_valid_o rises as it loads.
//   one transaction per cycle sustained while out_ready_i stays high; the decode
//   and state update are combinational between the two registers, the 16x8 rpm
//   multiply being the longest path.
// stalls:
//   while out_ready_i is low the result register holds and the input register
//   still takes one more sample; in_ready_o then drops until the result is taken.
// reset:
//   position, revolutions, edge count and latched velocity clear to zero, the
//   previous pin state to 00, counts_per_rev to 4000 and rpm_scale to 3.
module quadrature_position_velocity #(
  parameter int unsigned EDGE_COUNT_WIDTH = qpv_pkg::EDGE_COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [qpv_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [qpv_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  // sample channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                pin_a_i,
  input  logic                                pin_b_i,
  input  logic                                window_tick_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [13:0]                  count_in_rev_o,
  output logic [31:0]                         revolutions_o,
  output logic [15:0]                         edges_in_window_o,
  output logic [23:0]                         speed_rpm_o,
  output logic                                window_done_o
);
  import qpv_pkg::*;

  logic [CprWidth-1:0]         cpr_q;
  logic [ScaleWidth-1:0]       scale_q;

  logic                        s1_valid_q;
  logic                        s1_pin_a_q;
  logic                        s1_pin_b_q;
  logic                        s1_tick_q;
  logic                        s1_adv;

  qpv_state_t                  state_q, state_d;
  logic [EDGE_COUNT_WIDTH-1:0] edge_q, edge_d;

  logic                        res_valid_q;
  qpv_result_t                 res_q, res_d;
  logic                        res_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q   <= CPR_RESET;
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COUNTS_PER_REV: cpr_q   <= cfg_wdata_i[CprWidth-1:0];
        REG_RPM_SCALE:      scale_q <= cfg_wdata_i[ScaleWidth-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign res_free   = !res_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && res_free;
  assign in_ready_o = !s1_valid_q || res_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_pin_a_q <= pin_a_i;
      s1_pin_b_q <= pin_b_i;
      s1_tick_q  <= window_tick_i;
    end
  end

  // decode of the registered sample
  qpv_decode #(
    .EW(EDGE_COUNT_WIDTH)
  ) u_decode (
    .pin_a_i         (s1_pin_a_q),
    .pin_b_i         (s1_pin_b_q),
    .window_tick_i   (s1_tick_q),
    .counts_per_rev_i(cpr_q),
    .rpm_scale_i     (scale_q),
    .state_i         (state_q),
    .edge_cnt_i      (edge_q),
    .state_o         (state_d),
    .edge_cnt_o      (edge_d),
    .result_o        (res_d)
  );

  // state update when a sample moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      edge_q  <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
      edge_q  <= edge_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign count_in_rev_o    = res_q.count_in_rev;
  assign revolutions_o     = res_q.revolutions;
  assign edges_in_window_o = res_q.edges_in_window;
  assign speed_rpm_o       = res_q.speed_rpm;
  assign window_done_o     = res_q.window_done;

  // a closed window restarts the edge count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_tick_q) |=> (edge_q == '0))
    else $error("edge counter not cleared after window tick");

  // an unchanged pin state leaves position and revolutions alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && ({s1_pin_a_q, s1_pin_b_q} == state_q.last_pins))
    |=> ((state_q.count == $past(state_q.count)) && (state_q.revs == $past(state_q.revs))))
    else $error("position moved without a pin change");

  // revolutions move by at most one per transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> ((state_q.revs == $past(state_q.revs)) ||
                (state_q.revs == $past(state_q.revs) + 32'd1) ||
                (state_q.revs == $past(state_q.revs) - 32'd1)))
    else $error("revolution counter jumped");

  // a freshly loaded result mirrors the committed state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> ((res_q.count_in_rev == state_q.count) && (res_q.revolutions == state_q.revs)))
    else $error("result out of step with position state");

endmodule
